// File: hw/rtl/pcap_stream_deframer_unit_assert.svh
// assertion macros for the pcap stream deframer
`ifndef PCAP_STREAM_DEFRAMER_UNIT_ASSERT_SVH
`define PCAP_STREAM_DEFRAMER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define PSD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PSD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/psd_pkg.sv
// shared types, constants and helper functions of the pcap stream deframer
`default_nettype none

package psd_pkg;

	localparam int PSD_LENGTH_BITS = 16;
	localparam int PSD_CFG_INDEX_BITS = 4;

	localparam logic [31:0] MAGIC_NATIVE = 32'ha1b2c3d4;
	localparam logic [31:0] MAGIC_SWAPPED = 32'hd4c3b2a1;
	localparam logic [15:0] PCAP_VER_MAJOR = 16'd2;
	localparam logic [15:0] PCAP_VER_MINOR = 16'd4;

	// byte positions inside the global header
	localparam logic [4:0] GHDR_MAGIC_LAST = 5'd3;
	localparam logic [4:0] GHDR_VERSION_FIRST = 5'd4;
	localparam logic [4:0] GHDR_VERSION_LAST = 5'd7;
	localparam logic [4:0] GHDR_LINK_FIRST = 5'd20;
	localparam logic [4:0] GHDR_LAST = 5'd23;

	// byte positions inside a record header
	localparam logic [4:0] RHDR_SEC_LAST = 5'd3;
	localparam logic [4:0] RHDR_USEC_LAST = 5'd7;
	localparam logic [4:0] RHDR_LEN_LAST = 5'd11;
	localparam logic [4:0] RHDR_LAST = 5'd15;

	typedef enum logic [PSD_CFG_INDEX_BITS-1:0] {
		REG_LINK_TYPE = 4'd0,
		REG_MAX_LENGTH = 4'd1
	} reg_index_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_EMPTY = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ERR_FORMAT = 2'd0,
		ERR_LINK_TYPE = 2'd1,
		ERR_VERSION = 2'd2,
		ERR_TOO_LONG = 2'd3
	} err_code_t;

	typedef enum logic [3:0] {
		PH_GLOBAL = 4'b0001,
		PH_RECHDR = 4'b0010,
		PH_PAYLOAD = 4'b0100,
		PH_HALT = 4'b1000
	} phase_t;

	typedef struct packed {
		kind_t kind;
		err_code_t error_code;
		logic [7:0] payload_byte;
		logic [31:0] time_seconds;
		logic [31:0] time_micros;
		logic [15:0] record_length;
		logic first_of_record;
		logic last_of_record;
	} result_t;

	function automatic logic [31:0] swap32(input logic [31:0] v);
		swap32 = {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

	function automatic logic [31:0] order32(input logic swap, input logic [31:0] v);
		order32 = swap ? swap32(v) : v;
	endfunction

	function automatic logic [15:0] order16(input logic swap, input logic [15:0] v);
		order16 = swap ? {v[7:0], v[15:8]} : v;
	endfunction

	// fields arrive low byte first, so each byte enters at the top
	function automatic logic [31:0] shift_in(input logic [31:0] acc, input logic [7:0] b);
		shift_in = {b, acc[31:8]};
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/psd_if.sv
// stream and configuration channel interfaces of the pcap stream deframer
`default_nettype none

interface psd_in_if import psd_pkg::*; ();
	logic valid;
	logic ready;
	logic [7:0] data_byte;
	logic stream_start;

	modport source (output valid, output data_byte, output stream_start, input ready);
	modport sink (input valid, input data_byte, input stream_start, output ready);
endinterface

interface psd_out_if import psd_pkg::*; ();
	logic valid;
	logic ready;
	logic [1:0] kind;
	logic [1:0] error_code;
	logic [7:0] payload_byte;
	logic [31:0] time_seconds;
	logic [31:0] time_micros;
	logic [15:0] record_length;
	logic first_of_record;
	logic last_of_record;

	modport source (output valid, output kind, output error_code, output payload_byte,
		output time_seconds, output time_micros, output record_length,
		output first_of_record, output last_of_record, input ready);
	modport sink (input valid, input kind, input error_code, input payload_byte,
		input time_seconds, input time_micros, input record_length,
		input first_of_record, input last_of_record, output ready);
endinterface

interface psd_cfg_if import psd_pkg::*; ();
	logic valid;
	logic ready;
	logic [PSD_CFG_INDEX_BITS-1:0] index;
	logic [31:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/pcap_stream_deframer_unit.sv
// pcap stream deframer top level: header parse, record cutting and result register
//
//   channel      dir  request carries
//   byte_stream  in   data_byte, stream_start
//   result       out  kind, error_code, payload_byte, timestamp, length, first/last
//   cfg          in   register index, write data
//
// one input byte per cycle when ready; its result enters the result register next cycle
// the whole parse step is one pass of logic between the state registers and that register
// byte_stream.ready drops only while a held result is not taken by the result sink
// arst_n clears the parse state to the global header phase and loads register defaults
// after an error result the block halts until a byte marked stream_start
`default_nettype none

module pcap_stream_deframer_unit import psd_pkg::*; #(
	parameter int LENGTH_BITS = PSD_LENGTH_BITS
) (
	input wire logic clk,
	input wire logic arst_n,
	psd_in_if.sink byte_stream,
	psd_out_if.source result,
	psd_cfg_if.sink cfg
);

	`include "pcap_stream_deframer_unit_assert.svh"

	localparam logic [32:0] LenLimit = 33'((64'd1 << LENGTH_BITS) - 64'd1);

	// configuration registers
	logic [31:0] link_type_q;
	logic [15:0] max_length_q;

	// parse state
	phase_t phase_q, phase_d;
	logic [4:0] hdr_idx_q, hdr_idx_d;
	logic [31:0] field_q, field_d;
	logic swap_q, swap_d;
	logic [31:0] stamp_sec_q, stamp_sec_d;
	logic [31:0] stamp_usec_q, stamp_usec_d;
	logic [LENGTH_BITS-1:0] length_held_q, length_held_d;
	logic [LENGTH_BITS-1:0] bytes_left_q, bytes_left_d;

	// result register
	logic out_valid_q;
	result_t res_q;
	result_t res_d;
	logic emit;

	logic load;
	logic [7:0] b;
	phase_t ph_eff;
	logic [4:0] idx;
	logic [31:0] field_new;
	logic [31:0] len_word;
	logic first_b, last_b;

	assign cfg.ready = 1'b1;
	assign byte_stream.ready = !out_valid_q || result.ready;
	assign load = byte_stream.valid && byte_stream.ready;
	assign b = byte_stream.data_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_type_q <= 32'd1;
			max_length_q <= 16'hffff;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_LINK_TYPE: link_type_q <= cfg.data;
				REG_MAX_LENGTH: max_length_q <= cfg.data[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		ph_eff = byte_stream.stream_start ? PH_GLOBAL : phase_q;
		idx = byte_stream.stream_start ? 5'd0 : hdr_idx_q;
		field_new = shift_in(field_q, b);
		len_word = order32(swap_q, field_q);
		first_b = (bytes_left_q == length_held_q);
		last_b = (bytes_left_q <= LENGTH_BITS'(1));

		phase_d = ph_eff;
		hdr_idx_d = idx;
		field_d = field_q;
		swap_d = swap_q;
		stamp_sec_d = stamp_sec_q;
		stamp_usec_d = stamp_usec_q;
		length_held_d = length_held_q;
		bytes_left_d = bytes_left_q;

		emit = 1'b0;
		res_d = '0;
		res_d.kind = KIND_PAYLOAD;
		res_d.error_code = ERR_FORMAT;

		case (ph_eff)
			PH_GLOBAL: begin
				hdr_idx_d = idx + 5'd1;
				if (idx inside {[5'd0 : GHDR_MAGIC_LAST], [GHDR_LINK_FIRST : 5'd31]})
					field_d = field_new;
				else if (idx inside {[GHDR_VERSION_FIRST : GHDR_VERSION_LAST]})
					stamp_sec_d = shift_in(stamp_sec_q, b);
				if (idx == GHDR_MAGIC_LAST) begin
					if (field_new == MAGIC_NATIVE) begin
						swap_d = 1'b0;
					end else if (field_new == MAGIC_SWAPPED) begin
						swap_d = 1'b1;
					end else begin
						emit = 1'b1;
						res_d.kind = KIND_ERROR;
						res_d.error_code = ERR_FORMAT;
						phase_d = PH_HALT;
					end
				end
				if (idx >= GHDR_LAST) begin
					stamp_sec_d = '0;
					if (order32(swap_q, field_new) != link_type_q) begin
						emit = 1'b1;
						res_d.kind = KIND_ERROR;
						res_d.error_code = ERR_LINK_TYPE;
						phase_d = PH_HALT;
					end else if (order16(swap_q, stamp_sec_q[15:0]) != PCAP_VER_MAJOR ||
							order16(swap_q, stamp_sec_q[31:16]) != PCAP_VER_MINOR) begin
						emit = 1'b1;
						res_d.kind = KIND_ERROR;
						res_d.error_code = ERR_VERSION;
						phase_d = PH_HALT;
					end else begin
						phase_d = PH_RECHDR;
						hdr_idx_d = '0;
					end
				end
			end
			PH_RECHDR: begin
				hdr_idx_d = idx + 5'd1;
				if (idx <= RHDR_LEN_LAST)
					field_d = field_new;
				if (idx == RHDR_SEC_LAST)
					stamp_sec_d = order32(swap_q, field_new);
				else if (idx == RHDR_USEC_LAST)
					stamp_usec_d = order32(swap_q, field_new);
				if (idx >= RHDR_LAST) begin
					hdr_idx_d = '0;
					// captured length sits in the field register since byte 11
					if (len_word > {16'd0, max_length_q} || {1'b0, len_word} > LenLimit) begin
						emit = 1'b1;
						res_d.kind = KIND_ERROR;
						res_d.error_code = ERR_TOO_LONG;
						phase_d = PH_HALT;
					end else begin
						length_held_d = LENGTH_BITS'(len_word);
						bytes_left_d = LENGTH_BITS'(len_word);
						if (len_word == 32'd0) begin
							emit = 1'b1;
							res_d.kind = KIND_EMPTY;
							res_d.time_seconds = stamp_sec_q;
							res_d.time_micros = stamp_usec_q;
						end else begin
							phase_d = PH_PAYLOAD;
						end
					end
				end
			end
			PH_PAYLOAD: begin
				emit = 1'b1;
				res_d.kind = KIND_PAYLOAD;
				res_d.payload_byte = b;
				res_d.time_seconds = stamp_sec_q;
				res_d.time_micros = stamp_usec_q;
				res_d.record_length = 16'(length_held_q);
				res_d.first_of_record = first_b;
				res_d.last_of_record = last_b;
				bytes_left_d = last_b ? '0 : bytes_left_q - LENGTH_BITS'(1);
				if (last_b) begin
					phase_d = PH_RECHDR;
					hdr_idx_d = '0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_GLOBAL;
			hdr_idx_q <= '0;
			field_q <= '0;
			swap_q <= 1'b0;
			stamp_sec_q <= '0;
			stamp_usec_q <= '0;
			length_held_q <= '0;
			bytes_left_q <= '0;
		end else if (load) begin
			phase_q <= phase_d;
			hdr_idx_q <= hdr_idx_d;
			field_q <= field_d;
			swap_q <= swap_d;
			stamp_sec_q <= stamp_sec_d;
			stamp_usec_q <= stamp_usec_d;
			length_held_q <= length_held_d;
			bytes_left_q <= bytes_left_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load && emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && emit) begin
			res_q <= res_d;
		end
	end

	assign result.valid = out_valid_q;
	assign result.kind = res_q.kind;
	assign result.error_code = res_q.error_code;
	assign result.payload_byte = res_q.payload_byte;
	assign result.time_seconds = res_q.time_seconds;
	assign result.time_micros = res_q.time_micros;
	assign result.record_length = res_q.record_length;
	assign result.first_of_record = res_q.first_of_record;
	assign result.last_of_record = res_q.last_of_record;

	`PSD_ASSERT_NEXT(a_error_halts, load && emit && res_d.kind == KIND_ERROR,
		phase_q == PH_HALT, "error result without halt")
	`PSD_ASSERT_NOW(a_payload_count, phase_q == PH_PAYLOAD,
		bytes_left_q != '0 && bytes_left_q <= length_held_q, "payload count out of range")
	`PSD_ASSERT_NOW(a_hdr_index, phase_q == PH_RECHDR,
		hdr_idx_q <= RHDR_LAST, "record header index past end")
	`PSD_ASSERT_NOW(a_marks_on_payload, out_valid_q && (res_q.first_of_record ||
		res_q.last_of_record), res_q.kind == KIND_PAYLOAD, "record marks on a non-payload result")

endmodule

`default_nettype wire
